>>> rtl/sprite_scanline_evaluator_assert.svh
// Assertion macros used by the sprite scanline evaluator checker.
`ifndef SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH
`define SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sprite scanline evaluator: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sprite scanline evaluator: next-cycle check failed");

`endif

>>> rtl/sse_pkg.sv
// Package with the field widths and constants of the sprite scanline evaluator.
`timescale 1ns / 1ps
package sse_pkg;

  localparam int unsigned LineWidth   = 9;
  localparam int unsigned IndexWidth  = 9;
  localparam int unsigned CtlWidth    = 16;
  localparam int unsigned SlotWidth   = 7;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned RowsWidth   = 6;
  localparam int unsigned PosLsb      = 7;
  localparam int unsigned ChainBit    = 6;

  localparam int unsigned MaxPerLine  = 96;
  localparam int unsigned SpriteCount = 381;

endpackage

>>> rtl/sse_if.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
interface sse_in_if import sse_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [LineWidth-1:0]  scanline;
  logic [IndexWidth-1:0] sprite_id;
  logic [CtlWidth-1:0]   vert_word;
  logic                  last_sprite;

  modport source (output valid, scanline, sprite_id, vert_word, last_sprite, input ready);
  modport sink (input valid, scanline, sprite_id, vert_word, last_sprite, output ready);
endinterface

interface sse_out_if import sse_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  entry_valid;
  logic [SlotWidth-1:0]  slot;
  logic [IndexWidth-1:0] listed_id;
  logic                  scan_done;
  logic [CountWidth-1:0] active_count;

  modport source (output valid, entry_valid, slot, listed_id, scan_done, active_count,
                  input ready);
  modport sink (input valid, entry_valid, slot, listed_id, scan_done, active_count,
                output ready);
endinterface

>>> rtl/sprite_scanline_evaluator.sv
// The block takes one sprite control word per cycle unless an undrained result stalls it,
// reports appends to the active list and delivers its result, if any, in the cycle after
// acceptance; an item causes a result when the sprite is appended or when it is the last
// sprite of the scan. The throughput is set by the held Y, row count and list count, which
// are read and rewritten in the same cycle for each item. A single output register parts
// the two sides, so a new item is taken whenever that register is empty or being drained.
`timescale 1ns / 1ps
module sprite_scanline_evaluator import sse_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  sse_in_if.sink   in_i,
  sse_out_if.source out_o
);

  logic [LineWidth-1:0]  block_y_q, block_y_d;
  logic [RowsWidth-1:0]  block_rows_q, block_rows_d;
  logic [CountWidth-1:0] found_count_q, found_count_d;
  logic                  list_full_q, list_full_d;

  logic                  out_valid_q;
  logic                  entry_valid_q;
  logic [SlotWidth-1:0]  slot_q;
  logic [IndexWidth-1:0] listed_id_q;
  logic                  scan_done_q;
  logic [CountWidth-1:0] active_count_q;

  logic                  in_accept;
  logic                  scan_start;
  logic                  take;
  logic                  appended;
  logic                  emit;
  logic [LineWidth-1:0]  y_cur;
  logic [RowsWidth-1:0]  rows_cur;
  logic [CountWidth-1:0] count_cur;
  logic                  full_cur;
  logic [LineWidth-1:0]  line_offset;
  logic                  covers;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    scan_start = (in_i.sprite_id == '0);
    y_cur      = scan_start ? '0 : block_y_q;
    rows_cur   = scan_start ? '0 : block_rows_q;
    count_cur  = scan_start ? '0 : found_count_q;
    full_cur   = scan_start ? 1'b0 : list_full_q;

    take = !full_cur && ({1'b0, in_i.sprite_id} < (IndexWidth + 1)'(SpriteCount));

    block_y_d    = y_cur;
    block_rows_d = rows_cur;
    if (take && !in_i.vert_word[ChainBit]) begin
      block_y_d    = LineWidth'(0) - in_i.vert_word[CtlWidth-1:PosLsb];
      block_rows_d = in_i.vert_word[RowsWidth-1:0];
    end

    line_offset = in_i.scanline - block_y_d;
    covers      = block_rows_d[RowsWidth-1]
                  || ({1'b0, line_offset} < {block_rows_d, 4'b0000});
    appended    = take && (block_rows_d != '0) && covers;

    found_count_d = appended ? count_cur + CountWidth'(1) : count_cur;
    list_full_d   = full_cur || (appended && (found_count_d >= CountWidth'(MaxPerLine)));
    emit          = appended || in_i.last_sprite;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_y_q     <= '0;
      block_rows_q  <= '0;
      found_count_q <= '0;
      list_full_q   <= 1'b0;
    end else if (in_accept) begin
      block_y_q     <= block_y_d;
      block_rows_q  <= block_rows_d;
      found_count_q <= found_count_d;
      list_full_q   <= list_full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      entry_valid_q  <= appended;
      slot_q         <= appended ? count_cur : '0;
      listed_id_q    <= appended ? in_i.sprite_id : '0;
      scan_done_q    <= in_i.last_sprite;
      active_count_q <= found_count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.entry_valid  = entry_valid_q;
  assign out_o.slot         = slot_q;
  assign out_o.listed_id    = listed_id_q;
  assign out_o.scan_done    = scan_done_q;
  assign out_o.active_count = active_count_q;

endmodule

>>> rtl/sse_checker.sv
// Port-level checker for the sprite scanline evaluator and its bind statement.
`timescale 1ns / 1ps
`include "sprite_scanline_evaluator_assert.svh"
module sse_checker import sse_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  entry_valid_i,
  input logic [SlotWidth-1:0]  slot_i,
  input logic [IndexWidth-1:0] listed_id_i,
  input logic                  scan_done_i,
  input logic [CountWidth-1:0] active_count_i
);

  logic [SlotWidth+IndexWidth+CountWidth+1:0] result_bits;
  logic [SlotWidth-1:0]                       slot_next;

  assign result_bits = {entry_valid_i, slot_i, listed_id_i, scan_done_i, active_count_i};
  assign slot_next   = slot_i + SlotWidth'(1);

  // A waiting result keeps its value until the sink takes it.
  `SSE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(result_bits))

  // Every result is either an append or the end of a scan.
  `SSE_ASSERT_NOW(a_out_reason, out_valid_i, entry_valid_i || scan_done_i)

  // An append always reports the count just past the slot it filled.
  `SSE_ASSERT_NOW(a_count_follows_slot, out_valid_i && entry_valid_i, active_count_i == slot_next)

  // With no result waiting the block must be ready for a new item.
  `SSE_ASSERT_NOW(a_ready_when_empty, !out_valid_i, in_ready_i)

endmodule

bind sprite_scanline_evaluator sse_checker u_sse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .entry_valid_i  (out_o.entry_valid),
  .slot_i         (out_o.slot),
  .listed_id_i    (out_o.listed_id),
  .scan_done_i    (out_o.scan_done),
  .active_count_i (out_o.active_count)
);
